// ----- rtl/core/qrb_pkg.sv -----
`default_nettype none
// ============================================================================
// qrb_pkg : shared types and constants of the quadratic bisection core
// Fixed-point format, field widths, request and result structs, register
// indexes and the command and status bundles between controller and datapath.
// ============================================================================
package qrb_pkg;

  // Number format: two's complement Q(32-FRAC_BITS).FRAC_BITS.
  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int PREC_W    = 31;
  localparam int ITER_W    = 8;
  localparam int CNT_W     = ITER_W + 1;
  localparam int CFG_IDX_W = 3;

  // Evaluation widths. They cover the whole fixed-point range of FRAC_BITS
  // (8 to 30), so the quadratic is evaluated without any loss.
  localparam int MULA_W = DATA_W + 1;
  localparam int PROD_W = MULA_W + DATA_W;
  localparam int T_W    = 65;
  localparam int ACC_W  = 97;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

  // Reset values of the registers.
  localparam logic [DATA_W-1:0] RST_COEF     = 32'd65536;
  localparam logic [PREC_W-1:0] RST_PREC     = 31'd66;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 8'd100;

  // Result status codes.
  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_NOBRK = 2'd2;

  // Evaluation point selection.
  localparam logic [1:0] XSEL_A = 2'd0;
  localparam logic [1:0] XSEL_B = 2'd1;
  localparam logic [1:0] XSEL_C = 2'd2;

  // Multiplier step of one evaluation.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MUL0 = 2'd1;
  localparam logic [1:0] OP_MUL1 = 2'd2;
  localparam logic [1:0] OP_MUL2 = 2'd3;

  // Source of the result root.
  localparam logic [1:0] ROOT_MID  = 2'd0;
  localparam logic [1:0] ROOT_C    = 2'd1;
  localparam logic [1:0] ROOT_ZERO = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] bound_one;
    logic signed [DATA_W-1:0] bound_two;
  } qrb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root;
    logic        [1:0]        status;
  } qrb_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_square;
    logic signed [DATA_W-1:0] coef_linear;
    logic signed [DATA_W-1:0] coef_const;
    logic        [PREC_W-1:0] precision;
    logic        [ITER_W-1:0] max_iterations;
  } qrb_cfg_t;

  typedef struct packed {
    logic       load;
    logic [1:0] x_sel;
    logic [1:0] ev_op;
    logic       keep_fa;
    logic       keep_fb;
    logic       set_a_c;
    logic       set_b_c;
    logic       cap_mid;
    logic       fire;
    logic [1:0] root_sel;
    logic [1:0] status;
  } qrb_cmd_t;

  typedef struct packed {
    logic wide;
    logic lo_brk;
    logic hi_brk;
  } qrb_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/quadratic_root_bisection_core.sv -----
`default_nettype none
// ============================================================================
// quadratic_root_bisection_core : bisection root finder for a quadratic
// Finds a root of coef_square*x^2 + coef_linear*x + coef_const inside a
// requested interval, in signed Q16.16 fixed point.
// ============================================================================
//
// A request is taken on a clock edge where start is high and busy is low; it
// carries two interval ends in either order. The core orders them, evaluates
// the sign of the quadratic exactly at both ends and then halves the interval,
// keeping the half whose ends differ in sign (a zero counts as a change),
// until the width is no more than the precision register. The result (the
// final midpoint and a status: converged, iteration limit or no bracket) is
// presented for exactly one cycle with out_strobe high and cannot be held
// off, so the receiver must take it in that cycle. Each evaluation takes three
// multiplier steps on the one shared 33 by 32 bit multiplier, and one halving
// pass consists of those three steps, the bracket decision and the width
// check. Every pass at least roughly halves the width, so the reset stop
// width of 66 is reached within 26 passes and any non-zero stop width within
// 32 passes. The iteration limit can end a request sooner; with a stop width
// of nought the interval may stop shrinking at a width of one, and the limit
// then ends the request after max_iterations + 1 passes and one further
// evaluation. A missing bracket ends the request, with a zero root, at the
// pass that finds it. One request is processed at a time and busy stays high
// throughout.
// The configuration registers may only be written while busy is low.
//
module quadratic_root_bisection_core
  import qrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 start,
  output logic                 busy,
  input  qrb_in_t              in_req,
  // Result channel.
  output logic                 out_strobe,
  output qrb_out_t             out_res,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  qrb_cfg_t  cfg_r, cfg_nxt;
  qrb_cmd_t  cmd;
  qrb_stat_t stat;

  // Configuration registers. Writes to unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COEF_SQUARE:    cfg_nxt.coef_square    = cfg_wdata;
        REG_COEF_LINEAR:    cfg_nxt.coef_linear    = cfg_wdata;
        REG_COEF_CONST:     cfg_nxt.coef_const     = cfg_wdata;
        REG_PRECISION:      cfg_nxt.precision      = cfg_wdata[PREC_W-1:0];
        REG_MAX_ITERATIONS: cfg_nxt.max_iterations = cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_square    <= RST_COEF;
      cfg_r.coef_linear    <= RST_COEF;
      cfg_r.coef_const     <= RST_COEF;
      cfg_r.precision      <= RST_PREC;
      cfg_r.max_iterations <= RST_MAX_ITER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The sequencer decides, the datapath holds the bracket and evaluates.
  qrb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .max_iterations (cfg_r.max_iterations),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy),
    .out_strobe     (out_strobe)
  );

  qrb_datapath u_datapath (
    .clk     (clk),
    .in_req  (in_req),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

`ifndef SYNTH
  // An accepted request always keeps the core busy in the following cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
  ) else $error("core not busy after accepting a request");

  // A result strobe is never followed directly by another one.
  a_single_strobe: assert property (
    @(posedge clk) disable iff (!rst_n) out_strobe |=> !out_strobe
  ) else $error("back-to-back result strobes");

  // A result carries one of the defined status codes.
  a_status_code: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.status == ST_CONV || out_res.status == ST_LIMIT ||
                    out_res.status == ST_NOBRK)
  ) else $error("undefined result status");

  // A missing bracket always reports a zero root.
  a_nobrk_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.status == ST_NOBRK) |-> (out_res.root == '0)
  ) else $error("no-bracket result with non-zero root");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/qrb_datapath.sv -----
`default_nettype none
// ============================================================================
// qrb_datapath : interval registers, shared multiplier and sign evaluation
// Holds the bracket ends and their signs, evaluates the quadratic in three
// multiplier steps (Horner form) and applies the controller's updates.
// ============================================================================
module qrb_datapath
  import qrb_pkg::*;
(
  input  logic      clk,
  input  qrb_in_t   in_req,
  input  qrb_cfg_t  cfg,
  input  qrb_cmd_t  cmd,
  output qrb_stat_t stat,
  output qrb_out_t  out_res
);

  logic signed [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic                     fa_neg_r, fa_neg_nxt, fa_zero_r, fa_zero_nxt;
  logic                     fb_neg_r, fb_neg_nxt, fb_zero_r, fb_zero_nxt;
  logic        [T_W-1:0]    t_r, t_nxt;
  logic        [ACC_W-1:0]  acc_r, acc_nxt;
  qrb_out_t                 out_r, out_nxt;

  logic signed [DATA_W-1:0] x;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [PROD_W-1:0] prod;
  logic        [ACC_W-1:0]  prod_ext;
  logic        [T_W-1:0]    lin_ext;
  logic        [ACC_W-1:0]  const_ext;
  logic                     f_neg, f_zero, in_lt;
  logic        [DATA_W:0]   sum, diff;
  logic signed [DATA_W-1:0] mid;

  // Evaluation point and multiplier operand.
  always_comb begin
    case (cmd.x_sel)
      XSEL_A:  x = a_r;
      XSEL_B:  x = b_r;
      default: x = c_r;
    endcase
    case (cmd.ev_op)
      OP_MUL0: mul_a = {cfg.coef_square[DATA_W-1], cfg.coef_square};
      OP_MUL1: mul_a = {1'b0, t_r[DATA_W-1:0]};
      default: mul_a = t_r[T_W-1:DATA_W];
    endcase
  end

  assign prod      = mul_a * x;
  assign prod_ext  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign lin_ext   = {{(T_W-DATA_W){cfg.coef_linear[DATA_W-1]}}, cfg.coef_linear} << FRAC_BITS;
  assign const_ext = {{(ACC_W-DATA_W){cfg.coef_const[DATA_W-1]}}, cfg.coef_const}
                     << (2 * FRAC_BITS);

  // f = (cs*x + cl*2^F)*x + cc*2^2F, with the inner term split in two halves.
  always_comb begin
    t_nxt   = t_r;
    acc_nxt = acc_r;
    case (cmd.ev_op)
      OP_MUL0: t_nxt   = prod[T_W-1:0] + lin_ext;
      OP_MUL1: acc_nxt = prod_ext + const_ext;
      OP_MUL2: acc_nxt = acc_r + (prod_ext << DATA_W);
      default: ;
    endcase
  end

  assign f_neg  = acc_r[ACC_W-1];
  assign f_zero = (acc_r == '0);

  assign stat.lo_brk = fa_zero_r | f_zero | (fa_neg_r != f_neg);
  assign stat.hi_brk = fb_zero_r | f_zero | (fb_neg_r != f_neg);

  // Floor midpoint and interval width; the width is never negative.
  assign sum       = {a_r[DATA_W-1], a_r} + {b_r[DATA_W-1], b_r};
  assign mid       = sum[DATA_W:1];
  assign diff      = {b_r[DATA_W-1], b_r} - {a_r[DATA_W-1], a_r};
  assign stat.wide = diff > {2'b00, cfg.precision};

  assign in_lt = $signed(in_req.bound_one) < $signed(in_req.bound_two);

  always_comb begin
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    fa_neg_nxt  = fa_neg_r;
    fa_zero_nxt = fa_zero_r;
    fb_neg_nxt  = fb_neg_r;
    fb_zero_nxt = fb_zero_r;
    out_nxt     = out_r;
    if (cmd.load) begin
      a_nxt = in_lt ? in_req.bound_one : in_req.bound_two;
      b_nxt = in_lt ? in_req.bound_two : in_req.bound_one;
    end
    if (cmd.set_a_c) begin
      a_nxt = c_r;
    end
    if (cmd.set_b_c) begin
      b_nxt = c_r;
    end
    if (cmd.keep_fa || cmd.set_a_c) begin
      fa_neg_nxt  = f_neg;
      fa_zero_nxt = f_zero;
    end
    if (cmd.keep_fb || cmd.set_b_c) begin
      fb_neg_nxt  = f_neg;
      fb_zero_nxt = f_zero;
    end
    if (cmd.cap_mid) begin
      c_nxt = mid;
    end
    if (cmd.fire) begin
      case (cmd.root_sel)
        ROOT_MID: out_nxt.root = mid;
        ROOT_C:   out_nxt.root = c_r;
        default:  out_nxt.root = '0;
      endcase
      out_nxt.status = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    fa_neg_r  <= fa_neg_nxt;
    fa_zero_r <= fa_zero_nxt;
    fb_neg_r  <= fb_neg_nxt;
    fb_zero_r <= fb_zero_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    out_r     <= out_nxt;
  end

  assign out_res = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/qrb_ctrl.sv -----
`default_nettype none
// ============================================================================
// qrb_ctrl : bisection sequencer
// Steps the datapath through the end-point evaluations, the halving passes,
// the iteration limit and the final result strobe.
// ============================================================================
module qrb_ctrl
  import qrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ITER_W-1:0] max_iterations,
  input  qrb_stat_t         stat,
  output qrb_cmd_t          cmd,
  output logic              busy,
  output logic              out_strobe
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EV0   = 3'd1;
  localparam logic [2:0] S_EV1   = 3'd2;
  localparam logic [2:0] S_EV2   = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       tgt_r, tgt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             strobe_r, strobe_nxt;

  always_comb begin
    cmd        = '0;
    cmd.x_sel  = tgt_r;
    state_nxt  = state_r;
    tgt_nxt    = tgt_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          tgt_nxt   = XSEL_A;
          count_nxt = '0;
          state_nxt = S_EV0;
        end
      end
      S_EV0: begin
        cmd.ev_op = OP_MUL0;
        state_nxt = S_EV1;
      end
      S_EV1: begin
        cmd.ev_op = OP_MUL1;
        state_nxt = S_EV2;
      end
      S_EV2: begin
        cmd.ev_op = OP_MUL2;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        case (tgt_r)
          XSEL_A: begin
            cmd.keep_fa = 1'b1;
            tgt_nxt     = XSEL_B;
            state_nxt   = S_EV0;
          end
          XSEL_B: begin
            cmd.keep_fb = 1'b1;
            state_nxt   = S_CHECK;
          end
          default: begin
            if (count_r > {1'b0, max_iterations}) begin
              cmd.fire     = 1'b1;
              cmd.root_sel = ROOT_C;
              cmd.status   = ST_LIMIT;
              strobe_nxt   = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              if (stat.lo_brk) begin
                cmd.set_b_c = 1'b1;
                state_nxt   = S_CHECK;
              end else if (stat.hi_brk) begin
                cmd.set_a_c = 1'b1;
                state_nxt   = S_CHECK;
              end else begin
                cmd.fire     = 1'b1;
                cmd.root_sel = ROOT_ZERO;
                cmd.status   = ST_NOBRK;
                strobe_nxt   = 1'b1;
                state_nxt    = S_IDLE;
              end
            end
          end
        endcase
      end
      S_CHECK: begin
        if (stat.wide) begin
          cmd.cap_mid = 1'b1;
          tgt_nxt     = XSEL_C;
          state_nxt   = S_EV0;
        end else begin
          cmd.fire     = 1'b1;
          cmd.root_sel = ROOT_MID;
          cmd.status   = ST_CONV;
          strobe_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tgt_r    <= XSEL_A;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tgt_r    <= tgt_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule
`default_nettype wire
